[design/jxew_pkg.sv]
// Shared types, codes and character tables of the JSON/XML escaping writer.
`default_nettype none

package jxew_pkg;

    localparam int CAP_W = 13;
    localparam int ADDR_W = 12;
    localparam logic [CAP_W-1:0] MAX_CAPACITY = 13'd4096;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        OP_RAW     = 3'd0,
        OP_XML     = 3'd1,
        OP_JSON    = 3'd2,
        OP_FINISH  = 3'd3,
        OP_RESTART = 3'd4
    } op_t;

    // How the back end expands one queued item.
    typedef enum logic [2:0] {
        K_BYTE,     // data as is
        K_ESC2,     // backslash, then data
        K_UHEX,     // \u00 and two hex digits of data
        K_ENT,      // XML entity selected by data
        K_FINISH,
        K_RESTART
    } kind_t;

    typedef enum logic [2:0] {
        ENT_QUOT,
        ENT_APOS,
        ENT_LT,
        ENT_GT,
        ENT_AMP
    } ent_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] len;    // number of results, 1..6
        logic [7:0] data;
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } push_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
            r = 8'h30 + {4'd0, nib};
        else
            r = 8'h37 + {4'd0, nib};
        return r;
    endfunction

    function automatic logic [7:0] ent_char(input ent_t sel, input logic [2:0] idx);
        logic [7:0] r;
        r = 8'h3B; // ';'
        if (idx == 3'd0)
            r = 8'h26; // '&'
        else begin
            unique case (sel)
                ENT_QUOT: begin
                    unique case (idx)
                        3'd1: r = 8'h71; // q
                        3'd2: r = 8'h75; // u
                        3'd3: r = 8'h6F; // o
                        3'd4: r = 8'h74; // t
                        default: r = 8'h3B;
                    endcase
                end
                ENT_APOS: begin
                    unique case (idx)
                        3'd1: r = 8'h61; // a
                        3'd2: r = 8'h70; // p
                        3'd3: r = 8'h6F; // o
                        3'd4: r = 8'h73; // s
                        default: r = 8'h3B;
                    endcase
                end
                ENT_LT: begin
                    unique case (idx)
                        3'd1: r = 8'h6C; // l
                        3'd2: r = 8'h74; // t
                        default: r = 8'h3B;
                    endcase
                end
                ENT_GT: begin
                    unique case (idx)
                        3'd1: r = 8'h67; // g
                        3'd2: r = 8'h74; // t
                        default: r = 8'h3B;
                    endcase
                end
                ENT_AMP: begin
                    unique case (idx)
                        3'd1: r = 8'h61; // a
                        3'd2: r = 8'h6D; // m
                        3'd3: r = 8'h70; // p
                        default: r = 8'h3B;
                    endcase
                end
                default: r = 8'h3B;
            endcase
        end
        return r;
    endfunction

    // Byte number idx of the expansion of one queued item.
    function automatic logic [7:0] seq_byte(input desc_t d, input logic [2:0] idx);
        logic [7:0] r;
        unique case (d.kind)
            K_BYTE:  r = d.data;
            K_ESC2:  r = (idx == 3'd0) ? 8'h5C : d.data;
            K_UHEX: begin
                unique case (idx)
                    3'd0:    r = 8'h5C; // backslash
                    3'd1:    r = 8'h75; // u
                    3'd2:    r = 8'h30;
                    3'd3:    r = 8'h30;
                    3'd4:    r = hex_char(d.data[7:4]);
                    default: r = hex_char(d.data[3:0]);
                endcase
            end
            K_ENT:   r = ent_char(ent_t'(d.data[2:0]), idx);
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[design/jxew_if.sv]
// Handshake channel interfaces: input items, results and the capacity write port.
`default_nettype none

interface jxew_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] in_byte;

    modport source (output valid, output operation, output in_byte, input ready);
    modport sink (input valid, input operation, input in_byte, output ready);
endinterface

interface jxew_result_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [7:0]  out_byte;
    logic [11:0] address;
    logic        last;
    logic        overflow;
    logic [12:0] used_count;
    logic        finish_ok;

    modport source (output valid, output write_enable, output out_byte, output address,
                    output last, output overflow, output used_count, output finish_ok,
                    input ready);
    modport sink (input valid, input write_enable, input out_byte, input address,
                  input last, input overflow, input used_count, input finish_ok,
                  output ready);
endinterface

interface jxew_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/jxew_front.sv]
// Front end: accepts items and classifies each into a queued expansion descriptor.
`default_nettype none

module jxew_front (
    jxew_item_if.sink       items,
    input  logic            q_full,
    output jxew_pkg::push_t push
);
    import jxew_pkg::*;

    desc_t d;
    logic  known;
    logic [7:0] c;

    assign c = items.in_byte;
    assign items.ready = !q_full;

    always_comb
    begin
        d.kind = K_BYTE;
        d.len  = 3'd1;
        d.data = c;
        known  = 1'b1;
        unique case (items.operation)
            OP_RAW: ;
            OP_XML:
            begin
                unique case (c)
                    8'h22:   begin d.kind = K_ENT; d.len = 3'd6; d.data = {5'd0, ENT_QUOT}; end
                    8'h27:   begin d.kind = K_ENT; d.len = 3'd6; d.data = {5'd0, ENT_APOS}; end
                    8'h3C:   begin d.kind = K_ENT; d.len = 3'd4; d.data = {5'd0, ENT_LT}; end
                    8'h3E:   begin d.kind = K_ENT; d.len = 3'd4; d.data = {5'd0, ENT_GT}; end
                    8'h26:   begin d.kind = K_ENT; d.len = 3'd5; d.data = {5'd0, ENT_AMP}; end
                    default: ;
                endcase
            end
            OP_JSON:
            begin
                unique case (c)
                    8'h5C, 8'h22, 8'h2F: begin d.kind = K_ESC2; d.len = 3'd2; end
                    8'h08:   begin d.kind = K_ESC2; d.len = 3'd2; d.data = 8'h62; end
                    8'h09:   begin d.kind = K_ESC2; d.len = 3'd2; d.data = 8'h74; end
                    8'h0A:   begin d.kind = K_ESC2; d.len = 3'd2; d.data = 8'h6E; end
                    8'h0C:   begin d.kind = K_ESC2; d.len = 3'd2; d.data = 8'h66; end
                    8'h0D:   begin d.kind = K_ESC2; d.len = 3'd2; d.data = 8'h72; end
                    default:
                    begin
                        if (c < 8'h20)
                        begin
                            d.kind = K_UHEX;
                            d.len  = 3'd6;
                        end
                    end
                endcase
            end
            OP_FINISH:  d.kind = K_FINISH;
            OP_RESTART: d.kind = K_RESTART;
            default:    known = 1'b0;  // undefined codes are taken and dropped
        endcase
    end

    assign push.valid = items.valid && items.ready && known;
    assign push.desc  = d;

endmodule

`default_nettype wire

[design/jxew_queue.sv]
// Short descriptor queue between front and back ends.
`default_nettype none

module jxew_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  jxew_pkg::push_t push,
    output logic            full,
    output jxew_pkg::push_t head,
    input  logic            pop
);
    import jxew_pkg::*;

    desc_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               do_pop;

    assign full   = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign do_pop = pop && (count_reg != '0);

    assign head.valid = count_reg != '0;
    assign head.desc  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(push.valid) - (QPTR_W + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.desc;
    end

endmodule

`default_nettype wire

[design/jxew_back.sv]
// Back end: expands queued items byte by byte, tracks fill count and overflow.
`default_nettype none

module jxew_back (
    input  logic            clk,
    input  logic            rst_n,
    input  jxew_pkg::push_t head,
    output logic            pop,
    jxew_cfg_if.sink        cfg,
    jxew_result_if.source   results
);
    import jxew_pkg::*;

    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [CAP_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [2:0]        idx_reg, idx_next;
    logic              res_valid_reg, res_valid_next;

    logic              we_reg, we_next;
    logic [7:0]        byte_reg, byte_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              last_reg, last_next;
    logic              res_ovf_reg, res_ovf_next;
    logic [CAP_W-1:0]  used_reg, used_next;
    logic              fin_reg, fin_next;

    logic [CAP_W-1:0]  limit;
    logic              fit;
    logic              room;
    logic              step;
    logic              is_last;

    assign cfg.ready = 1'b1;

    assign limit   = (cap_reg < MAX_CAPACITY) ? cap_reg : MAX_CAPACITY;
    assign fit     = count_reg < limit;
    assign room    = fit && !ovf_reg;
    assign step    = head.valid && (!res_valid_reg || results.ready);
    assign is_last = idx_reg == (head.desc.len - 3'd1);
    assign pop     = step && is_last;

    always_comb
    begin
        cap_next       = (cfg.valid && cfg.ready) ? cfg.data : cap_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg;
        if (results.ready)
            res_valid_next = 1'b0;

        we_next      = we_reg;
        byte_next    = byte_reg;
        addr_next    = addr_reg;
        last_next    = last_reg;
        res_ovf_next = res_ovf_reg;
        used_next    = used_reg;
        fin_next     = fin_reg;

        if (step)
        begin
            res_valid_next = 1'b1;
            idx_next       = is_last ? 3'd0 : idx_reg + 3'd1;
            last_next      = is_last;
            byte_next      = seq_byte(head.desc, idx_reg);
            addr_next      = count_reg[ADDR_W-1:0];
            fin_next       = 1'b0;
            unique case (head.desc.kind)
                K_FINISH:
                begin
                    we_next      = fit;
                    res_ovf_next = ovf_reg;
                    used_next    = count_reg;
                    fin_next     = room;
                end
                K_RESTART:
                begin
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    we_next      = 1'b0;
                    addr_next    = '0;
                    res_ovf_next = 1'b0;
                    used_next    = '0;
                end
                default:
                begin
                    // once a data byte is dropped, every later data byte is dropped until restart
                    count_next   = room ? count_reg + 1'b1 : count_reg;
                    ovf_next     = !room;
                    we_next      = room;
                    res_ovf_next = !room;
                    used_next    = count_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        we_reg      <= we_next;
        byte_reg    <= byte_next;
        addr_reg    <= addr_next;
        last_reg    <= last_next;
        res_ovf_reg <= res_ovf_next;
        used_reg    <= used_next;
        fin_reg     <= fin_next;
    end

    assign results.valid        = res_valid_reg;
    assign results.write_enable = we_reg;
    assign results.out_byte     = byte_reg;
    assign results.address      = addr_reg;
    assign results.last         = last_reg;
    assign results.overflow     = res_ovf_reg;
    assign results.used_count   = used_reg;
    assign results.finish_ok    = fin_reg;

endmodule

`default_nettype wire

[design/json_xml_escaping_writer.sv]
// Top level of the JSON/XML escaping byte writer.
// Each input item (operation, byte) turns into one to six result bytes, each
// tagged with its buffer address, a write enable and the running fill count.
// The front end takes one item per cycle into a four-entry queue unless it is
// full; the back end emits one result per cycle from an output register unless
// stalled, so plain bytes run at one item per cycle and an escaped byte holds
// the back end until all its bytes are out (two for a JSON backslash pair, four
// to six for XML entities and \u00XX). The queue absorbs short bursts of escapes
// before ready drops. The user must write capacity through the cfg port only
// while the block is idle; the block does not enforce this. It resets to 4096
// and is limited to 4096. Undefined operation codes are accepted and produce no result.
`default_nettype none

module json_xml_escaping_writer (
    input  logic          clk,
    input  logic          rst_n,
    jxew_item_if.sink     items,
    jxew_result_if.source results,
    jxew_cfg_if.sink      cfg
);
    import jxew_pkg::*;

    push_t push;
    push_t head;
    logic  q_full;
    logic  pop;

    jxew_front u_front (
        .items  (items),
        .q_full (q_full),
        .push   (push)
    );

    jxew_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    jxew_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .cfg     (cfg),
        .results (results)
    );

endmodule

`default_nettype wire

[design/jxew_checker.sv]
// Port-level checks of the escaping writer, bound to the top level.
`default_nettype none

module jxew_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        write_enable,
    input logic [7:0]  out_byte,
    input logic [11:0] address,
    input logic        last,
    input logic        overflow,
    input logic [12:0] used_count,
    input logic        finish_ok
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(address))
        else $error("result changed while stalled");

    // a stored byte advances the count by one, except the terminator
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && write_enable |->
            used_count == ({1'b0, address} + 13'd1) ||
            (last && out_byte == 8'h00 && used_count == {1'b0, address}))
        else $error("fill count does not match address");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && finish_ok |-> write_enable && !overflow && last && out_byte == 8'h00)
        else $error("finish_ok without a stored terminator");

    // a dropped byte other than a terminator means overflow
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !write_enable && out_byte != 8'h00 |-> overflow)
        else $error("byte dropped without overflow");

endmodule

bind json_xml_escaping_writer jxew_checker u_jxew_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .write_enable (results.write_enable),
    .out_byte     (results.out_byte),
    .address      (results.address),
    .last         (results.last),
    .overflow     (results.overflow),
    .used_count   (results.used_count),
    .finish_ok    (results.finish_ok)
);

`default_nettype wire
